[hdl/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// No dependencies; assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[hdl/ffra_pkg.sv]
// Package for the first-fit range allocator: types, codes and constants.
// No dependencies.
package ffra_pkg;
   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned MAX_RANGES_DEF = 16;
   localparam logic [ADDR_W-1:0] POOL_RESET = 16'd1000;
   localparam logic [ADDR_W-1:0] ADDR_TOP   = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_INIT = 2'd0, OP_ALLOC = 2'd1, OP_FREE = 2'd2, OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NO_FIT = 2'd1, ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      op_type            operation;
      logic [ADDR_W-1:0] request_size;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] granted_address;
      logic [ADDR_W-1:0] total_free;
      logic [ADDR_W-1:0] largest_free;
   } rsp_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;      // capture request
      logic init;      // table := [0,pool)
      logic alloc;     // perform allocate at found index
      logic free_ins;  // perform free using computed span
      logic sum;       // recompute totals
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic scan_done;
      logic sum_done;
   } stat_type;
endpackage

[hdl/ffra_datapath.sv]
// Datapath of the range allocator: range table, scan and update logic.
// Depends on ffra_pkg.
module ffra_datapath import ffra_pkg::*; #(
   parameter int unsigned MAX_RANGES = MAX_RANGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] pool_size,
   input  req_type           req,
   input  cmd_type           cmd,
   input  logic              scan_start,
   output stat_type          stat,
   output rsp_type           rsp
);
   localparam int unsigned IW = $clog2(MAX_RANGES);
   localparam int unsigned CW = $clog2(MAX_RANGES + 1);

   logic [ADDR_W-1:0] start_ff [MAX_RANGES];
   logic [ADDR_W-1:0] end_ff   [MAX_RANGES];
   logic [CW-1:0]     count_ff;
   req_type           req_ff;
   logic [CW-1:0]     idx_ff;
   logic              scanning_ff, summing_ff;
   logic              found_ff;
   logic [CW-1:0]     fidx_ff, lo_ff, hi_ff, pos_ff;
   logic              lomerge_ff, posdone_ff;
   logic [ADDR_W-1:0] ns_ff, ne_ff;
   logic              empty_free_ff;
   logic [ADDR_W-1:0] total_ff, largest_ff;
   status_type        status_ff;
   logic [ADDR_W-1:0] granted_ff;

   logic [IW-1:0]     ix;
   logic [ADDR_W-1:0] cs, ce, clen;
   logic              in_range;
   logic [ADDR_W:0]   fe_sum;
   logic [ADDR_W-1:0] clen_f, uns;
   logic [CW-1:0]     ulo, removed;

   assign ix       = idx_ff[IW-1:0];
   assign cs       = start_ff[ix];
   assign ce       = end_ff[ix];
   assign clen     = ce - cs;
   assign in_range = idx_ff < count_ff;
   assign fe_sum   = {1'b0, req.free_address} + {1'b0, req.request_size};

   assign stat.scan_done = scanning_ff && !in_range;
   assign stat.sum_done  = summing_ff && !in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= CW'(1);
         start_ff[0] <= '0;
         end_ff[0]   <= POOL_RESET;
         scanning_ff <= 1'b0;
         summing_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            req_ff      <= req;
            idx_ff      <= '0;
            found_ff    <= 1'b0;
            posdone_ff  <= 1'b0;
            pos_ff      <= '0;
            lomerge_ff  <= 1'b0;
            hi_ff       <= '0;
            ns_ff       <= req.free_address;
            ne_ff       <= fe_sum > {1'b0, ADDR_TOP} ? ADDR_TOP : fe_sum[ADDR_W-1:0];
            empty_free_ff <= 1'b0;
            status_ff   <= ST_OK;
            granted_ff  <= '0;
         end
         if (scan_start) begin
            scanning_ff <= 1'b1;
            empty_free_ff <= ne_ff <= ns_ff;
         end
         if (scanning_ff && in_range) begin
            idx_ff <= idx_ff + CW'(1);
            if (req_ff.operation == OP_ALLOC) begin
               if (!found_ff && clen >= req_ff.request_size) begin
                  found_ff <= 1'b1;
                  fidx_ff  <= idx_ff;
               end
            end else if (!posdone_ff) begin
               if (cs <= ns_ff) begin
                  pos_ff <= idx_ff + CW'(1);
                  if (ce >= ns_ff) begin
                     lomerge_ff <= 1'b1;
                     lo_ff      <= idx_ff;
                     if (ce > ne_ff) ne_ff <= ce;
                  end else begin
                     lomerge_ff <= 1'b0;
                  end
                  hi_ff <= idx_ff + CW'(1);
               end else begin
                  posdone_ff <= 1'b1;
                  if (cs <= ne_ff) begin
                     hi_ff <= idx_ff + CW'(1);
                     if (ce > ne_ff) ne_ff <= ce;
                  end else begin
                     hi_ff <= idx_ff;
                  end
               end
            end else if (hi_ff == idx_ff && cs <= ne_ff) begin
               hi_ff <= idx_ff + CW'(1);
               if (ce > ne_ff) ne_ff <= ce;
            end
         end
         if (stat.scan_done) scanning_ff <= 1'b0;
         if (cmd.init) begin
            start_ff[0] <= '0;
            end_ff[0]   <= pool_size;
            count_ff    <= (pool_size == '0) ? '0 : CW'(1);
         end
         if (cmd.alloc) begin
            if (found_ff) begin
               granted_ff <= start_ff[fidx_ff[IW-1:0]];
               if (clen_f == req_ff.request_size && req_ff.request_size != '0) begin
                  for (int i = 0; i < MAX_RANGES - 1; i++)
                     if (CW'(i) >= fidx_ff) begin
                        start_ff[i] <= start_ff[i+1];
                        end_ff[i]   <= end_ff[i+1];
                     end
                  count_ff <= count_ff - CW'(1);
               end else begin
                  start_ff[fidx_ff[IW-1:0]] <= start_ff[fidx_ff[IW-1:0]]
                                              + req_ff.request_size;
               end
            end else begin
               status_ff <= ST_NO_FIT;
            end
         end
         if (cmd.free_ins && !empty_free_ff) begin
            if (removed == '0 && count_ff >= CW'(MAX_RANGES)) begin
               status_ff <= ST_FULL;
            end else begin
               for (int i = 0; i < MAX_RANGES; i++) begin
                  if (removed == '0) begin
                     if (CW'(i) > ulo && i > 0) begin
                        start_ff[i] <= start_ff[i-1];
                        end_ff[i]   <= end_ff[i-1];
                     end
                  end else if (CW'(i) > ulo && i + int'(removed) - 1 < MAX_RANGES) begin
                     start_ff[i] <= start_ff[i + int'(removed) - 1];
                     end_ff[i]   <= end_ff[i + int'(removed) - 1];
                  end
               end
               start_ff[ulo[IW-1:0]] <= uns;
               end_ff[ulo[IW-1:0]]   <= ne_ff;
               count_ff <= count_ff - removed + CW'(1);
            end
         end
         if (cmd.sum) begin
            summing_ff <= 1'b1;
            idx_ff     <= '0;
            total_ff   <= '0;
            largest_ff <= '0;
         end
         if (summing_ff && in_range) begin
            idx_ff   <= idx_ff + CW'(1);
            total_ff <= total_ff + clen;
            if (clen > largest_ff) largest_ff <= clen;
         end
         if (stat.sum_done) summing_ff <= 1'b0;
      end
   end

   assign clen_f  = end_ff[fidx_ff[IW-1:0]] - start_ff[fidx_ff[IW-1:0]];
   assign ulo     = lomerge_ff ? lo_ff : pos_ff;
   assign uns     = lomerge_ff ? start_ff[lo_ff[IW-1:0]] : ns_ff;
   assign removed = hi_ff - ulo;

   assign rsp.status          = status_ff;
   assign rsp.granted_address = granted_ff;
   assign rsp.total_free      = total_ff;
   assign rsp.largest_free    = largest_ff;
endmodule

[hdl/ffra_ctrl.sv]
// Controller of the range allocator: sequences load, scan, update and sum.
// Depends on ffra_pkg.
module ffra_ctrl import ffra_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  op_type   op,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     scan_start,
   output logic     busy,
   output logic     done
);
   typedef enum logic [2:0] {S_IDLE, S_PREP, S_SCAN, S_UPD, S_SUM, S_DONE} state_type;
   state_type state_ff;
   op_type    op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_QUERY;
      end else begin
         unique case (state_ff)
            S_IDLE: if (start) begin
               op_ff <= op;
               unique case (op) inside
                  OP_ALLOC, OP_FREE: state_ff <= S_PREP;
                  OP_INIT:           state_ff <= S_UPD;
                  default:           state_ff <= S_SUM;
               endcase
            end
            S_PREP: state_ff <= S_SCAN;
            S_SCAN: if (stat.scan_done) state_ff <= S_UPD;
            S_UPD:  state_ff <= S_SUM;
            S_SUM:  if (stat.sum_done) state_ff <= S_DONE;
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == S_IDLE) && start;
      scan_start   = state_ff == S_PREP;
      cmd.init     = (state_ff == S_UPD) && op_ff == OP_INIT;
      cmd.alloc    = (state_ff == S_UPD) && op_ff == OP_ALLOC;
      cmd.free_ins = (state_ff == S_UPD) && op_ff == OP_FREE;
      cmd.sum      = ((state_ff == S_UPD) || ((state_ff == S_IDLE) && start
                     && op == OP_QUERY));
   end

   assign busy = state_ff != S_IDLE;
   assign done = state_ff == S_DONE;
endmodule

[hdl/first_fit_range_allocator.sv]
// First-fit range allocator top level: controller, datapath, pool size register.
// Depends on ffra_pkg, ffra_ctrl, ffra_datapath and assert_macros.svh.
// Each allocate or free makes one serial pass over the table to find the fit or
// merge span and a second serial pass to sum the free space; an init updates the
// table and then sums it, and a query only sums it. Busy is high while a request
// is in work, and no new request is taken until it is done; rsp_valid is high for
// one cycle with the response on rsp_data, and the response cannot be stalled.
`include "assert_macros.svh"
module first_fit_range_allocator import ffra_pkg::*; #(
   parameter int unsigned MAX_RANGES = MAX_RANGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_wdata
);
   logic [ADDR_W-1:0] pool_ff;
   cmd_type  cmd;
   stat_type stat;
   logic     scan_start;

   always_ff @(posedge clock) begin
      if (reset) pool_ff <= POOL_RESET;
      else if (csr_we) pool_ff <= csr_wdata;
   end

   ffra_ctrl u_ctrl (
      .clock, .reset, .start, .op(req_data.operation), .stat, .cmd,
      .scan_start, .busy, .done(rsp_valid)
   );

   ffra_datapath #(.MAX_RANGES(MAX_RANGES)) u_dp (
      .clock, .reset, .pool_size(pool_ff), .req(req_data), .cmd, .scan_start,
      .stat, .rsp(rsp_data)
   );

   `ASSERT_NEXT(a_done_pulse, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMPLIES(a_done_busy, clock, reset, rsp_valid, busy)
   `ASSERT_IMPLIES(a_grant_ok, clock, reset, rsp_valid && rsp_data.status != ST_OK,
                   rsp_data.granted_address == '0)
endmodule
